// ----- src/atc_pkg.sv -----
// Shared types and constants for the compacting alarm table.
// Used by atc_cell and alarm_table_compacting; no dependencies.
package atc_pkg;

    localparam int ID_W        = 32;
    localparam int SEV_W       = 3;
    localparam int RD_IDX_W    = 8;
    localparam int CNT_OUT_W   = 9;
    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [1:0] CMD_RAISE = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SEV_W-1:0] sev;
    } entry_t;

    typedef struct packed {
        logic                raise_we;
        logic [ID_W-1:0]     new_id;
        logic [SEV_W-1:0]    new_sev;
        logic                ack;
        logic [ID_W-1:0]     ack_id;
        logic [RD_IDX_W-1:0] rd_index;
    } cell_ctrl_t;

endpackage

// ----- src/atc_cell.sv -----
// One table position: holds an entry, compares it against the ack id,
// shifts down from its upper neighbor and feeds the read chain. Uses atc_pkg.
module atc_cell #(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 5
) (
    input  logic               clk,
    input  atc_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]   count,
    input  logic               match_in,
    output logic               match_out,
    input  atc_pkg::entry_t    next_entry,
    output atc_pkg::entry_t    entry,
    input  atc_pkg::entry_t    rd_in,
    output atc_pkg::entry_t    rd_out
);
    import atc_pkg::*;

    localparam logic [CNT_W:0]      IDX    = CELL_INDEX[CNT_W:0];
    localparam logic [RD_IDX_W-1:0] RD_IDX = CELL_INDEX[RD_IDX_W-1:0];

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;
    logic   tail;

    assign occupied  = IDX < {1'b0, count};
    assign tail      = ctrl.raise_we && ({1'b0, count} == IDX);
    assign match_out = match_in || (occupied && (entry_reg.id == ctrl.ack_id));

    always_comb
    begin
        entry_next = entry_reg;
        if (tail)
        begin
            entry_next.id  = ctrl.new_id;
            entry_next.sev = ctrl.new_sev;
        end
        else if (ctrl.ack && match_out)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry  = entry_reg;
    assign rd_out = rd_in | ((ctrl.rd_index == RD_IDX) ? entry_reg : '0);

endmodule

// ----- src/alarm_table_compacting.sv -----
// Top level of the compacting alarm table: command decode, counters,
// output register and the chain of atc_cell positions. Uses atc_pkg.
//
// Usage:
//   Command channel req_valid/req_stall carries cmd, severity, ack_id and
//   read_index. Result channel rsp_valid/rsp_stall carries status, stored,
//   new_id, entry_id, entry_severity and active_count, one result per item.
//   silenced_we/silenced_wdata write the silence register; write it only
//   while no item is in flight.
// Latency and throughput:
//   An accepted item updates the cell chain and the result register at the
//   same edge; its result is valid the next cycle. One item per cycle while
//   the receiver does not stall. The ack match is an OR ripple through the
//   TABLE_DEPTH cells, which sets the cycle time.
// Reset:
//   rst_n clears the entry count, the id counter, the silence register and
//   the result valid. Entry storage is not cleared.
// Stall:
//   While a result is held by rsp_stall, req_stall is raised and no new
//   item is taken; the held result does not change.
module alarm_table_compacting #(
    parameter int TABLE_DEPTH = atc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               silenced_we,
    input  logic                               silenced_wdata,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [1:0]                         cmd,
    input  logic [atc_pkg::SEV_W-1:0]          severity,
    input  logic [atc_pkg::ID_W-1:0]           ack_id,
    input  logic [atc_pkg::RD_IDX_W-1:0]       read_index,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [1:0]                         status,
    output logic                               stored,
    output logic [atc_pkg::ID_W-1:0]           new_id,
    output logic [atc_pkg::ID_W-1:0]           entry_id,
    output logic [atc_pkg::SEV_W-1:0]          entry_severity,
    output logic [atc_pkg::CNT_OUT_W-1:0]      active_count
);
    import atc_pkg::*;

    localparam int              CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = TABLE_DEPTH[CNT_W-1:0];

    logic                 rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ID_W-1:0]      id_ctr_reg, id_ctr_next;
    logic                 silenced_reg, silenced_next;

    logic [1:0]           status_reg, status_next;
    logic                 stored_reg, stored_next;
    logic [ID_W-1:0]      new_id_reg, new_id_next;
    logic [ID_W-1:0]      entry_id_reg, entry_id_next;
    logic [SEV_W-1:0]     entry_sev_reg, entry_sev_next;
    logic [CNT_OUT_W-1:0] active_reg, active_next;

    logic       accept;
    logic       in_range;
    logic       found;
    logic       full;
    cell_ctrl_t ctrl;

    logic   match_chain [TABLE_DEPTH+1];
    entry_t rd_chain    [TABLE_DEPTH+1];
    entry_t cell_entry  [TABLE_DEPTH];
    entry_t cell_next   [TABLE_DEPTH];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == FULL_CNT);
    assign in_range  = {1'b0, read_index} < CNT_OUT_W'(count_reg);
    assign found     = match_chain[TABLE_DEPTH];

    assign id_ctr_next = id_ctr_reg + ID_W'(1);

    always_comb
    begin
        ctrl.raise_we = accept && (cmd == CMD_RAISE) && !silenced_reg && !full;
        ctrl.new_id   = id_ctr_next;
        ctrl.new_sev  = severity;
        ctrl.ack      = accept && (cmd == CMD_ACK);
        ctrl.ack_id   = ack_id;
        ctrl.rd_index = read_index;
    end

    assign match_chain[0] = 1'b0;
    assign rd_chain[0]    = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign cell_next[gi] = '0;
            end
            else
            begin : g_mid
                assign cell_next[gi] = cell_entry[gi+1];
            end

            atc_cell #(
                .CELL_INDEX (gi),
                .CNT_W      (CNT_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .match_in   (match_chain[gi]),
                .match_out  (match_chain[gi+1]),
                .next_entry (cell_next[gi]),
                .entry      (cell_entry[gi]),
                .rd_in      (rd_chain[gi]),
                .rd_out     (rd_chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        silenced_next  = silenced_we ? silenced_wdata : silenced_reg;
        rsp_valid_next = accept ? 1'b1 : (rsp_valid_reg && rsp_stall);
        status_next    = ST_OK;
        stored_next    = 1'b0;
        new_id_next    = '0;
        entry_id_next  = '0;
        entry_sev_next = '0;
        unique case (cmd)
            CMD_RAISE:
            begin
                if (!silenced_reg && full)
                begin
                    status_next = ST_FULL;
                end
                else if (!silenced_reg)
                begin
                    stored_next = 1'b1;
                    new_id_next = id_ctr_next;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            CMD_ACK:
            begin
                if (found)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            CMD_READ:
            begin
                if (in_range)
                begin
                    entry_id_next  = rd_chain[TABLE_DEPTH].id;
                    entry_sev_next = rd_chain[TABLE_DEPTH].sev;
                end
                else
                begin
                    status_next = ST_BAD_INDEX;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        active_next = CNT_OUT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            id_ctr_reg    <= '0;
            silenced_reg  <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            silenced_reg  <= silenced_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (ctrl.raise_we)
            begin
                id_ctr_reg <= id_ctr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            stored_reg    <= stored_next;
            new_id_reg    <= new_id_next;
            entry_id_reg  <= entry_id_next;
            entry_sev_reg <= entry_sev_next;
            active_reg    <= active_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign stored         = stored_reg;
    assign new_id         = new_id_reg;
    assign entry_id       = entry_id_reg;
    assign entry_severity = entry_sev_reg;
    assign active_count   = active_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_OUT_W'(count_reg) <= CNT_OUT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_stored_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && stored_reg) |-> (status_reg == ST_OK))
        else $error("stored result without ok status");

    a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.raise_we |=> (id_ctr_reg == $past(id_ctr_next)))
        else $error("id counter did not advance on stored raise");

    a_count_report: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (active_reg == CNT_OUT_W'(count_reg)))
        else $error("reported count differs from table count");

endmodule

// ----- tb/sv/tb_alarm_table_compacting.sv -----
// Self-checking testbench for alarm_table_compacting: raise, ack and read commands
// under random idling on both channels, checked against an in-bench table model.
// Depends on atc_pkg and alarm_table_compacting.
module tb_alarm_table_compacting;
    import atc_pkg::*;

    localparam int TBL_DEPTH      = TABLE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [SEV_W-1:0]    sev;
        logic [ID_W-1:0]     ack_id;
        logic [RD_IDX_W-1:0] idx;
    } alarm_cmd_t;

    typedef struct packed {
        alarm_cmd_t c;
        logic       aim;
    } staged_cmd_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 stored;
        logic [ID_W-1:0]      new_id;
        logic [ID_W-1:0]      entry_id;
        logic [SEV_W-1:0]     entry_sev;
        logic [CNT_OUT_W-1:0] active_count;
    } alarm_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic silenced_we = 1'b0;
    logic silenced_wdata = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic [1:0] cmd = CMD_RAISE;
    logic [SEV_W-1:0] severity = '0;
    logic [ID_W-1:0] ack_id = '0;
    logic [RD_IDX_W-1:0] read_index = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic [1:0] status;
    logic stored;
    logic [ID_W-1:0] new_id;
    logic [ID_W-1:0] entry_id;
    logic [SEV_W-1:0] entry_severity;
    logic [CNT_OUT_W-1:0] active_count;

    alarm_table_compacting #(.TABLE_DEPTH(TBL_DEPTH)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .silenced_we    (silenced_we),
        .silenced_wdata (silenced_wdata),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .cmd            (cmd),
        .severity       (severity),
        .ack_id         (ack_id),
        .read_index     (read_index),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .stored         (stored),
        .new_id         (new_id),
        .entry_id       (entry_id),
        .entry_severity (entry_severity),
        .active_count   (active_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // table model
    logic [ID_W-1:0]  tbl_id  [TBL_DEPTH];
    logic [SEV_W-1:0] tbl_sev [TBL_DEPTH];
    int unsigned      tbl_count = 0;
    logic [ID_W-1:0]  id_ctr = '0;
    logic             quiet_mode = 1'b0;

    staged_cmd_t pending_q[$];
    alarm_rsp_t  expected_rsp_q[$];
    alarm_cmd_t  offered;
    alarm_rsp_t  want_rsp;

    int items_sent = 0;
    int results_seen = 0;
    int fail_count = 0;
    int hold_left = 0;
    int stuck_cycles = 0;
    int status_hits [4] = '{0, 0, 0, 0};
    int stored_hits = 0;

    function automatic alarm_rsp_t apply_command(alarm_cmd_t c);
        alarm_rsp_t r;
        int hit;
        int i;
        r = '0;
        case (c.cmd)
            CMD_RAISE:
            begin
                if (quiet_mode)
                    r.status = ST_OK;
                else if (tbl_count >= TBL_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    id_ctr = id_ctr + 1'b1;
                    tbl_id[tbl_count] = id_ctr;
                    tbl_sev[tbl_count] = c.sev;
                    tbl_count++;
                    r.stored = 1'b1;
                    r.new_id = id_ctr;
                end
            end
            CMD_ACK:
            begin
                r.status = ST_NOT_FOUND;
                hit = -1;
                for (i = 0; i < tbl_count; i++)
                    if (hit < 0 && tbl_id[i] == c.ack_id)
                        hit = i;
                if (hit >= 0)
                begin
                    for (i = hit; i + 1 < tbl_count; i++)
                    begin
                        tbl_id[i] = tbl_id[i + 1];
                        tbl_sev[i] = tbl_sev[i + 1];
                    end
                    tbl_count--;
                    r.status = ST_OK;
                end
            end
            CMD_READ:
            begin
                if (c.idx < tbl_count)
                begin
                    r.entry_id = tbl_id[c.idx];
                    r.entry_sev = tbl_sev[c.idx];
                end
                else
                    r.status = ST_BAD_INDEX;
            end
            default: ;
        endcase
        r.active_count = CNT_OUT_W'(tbl_count);
        return r;
    endfunction

    // aimed acks and reads pick a live entry at issue time
    function automatic alarm_cmd_t aim_command(staged_cmd_t s);
        alarm_cmd_t c;
        c = s.c;
        if (s.aim && tbl_count > 0)
        begin
            if (c.cmd == CMD_ACK)
                c.ack_id = tbl_id[$urandom_range(0, tbl_count - 1)];
            else if (c.cmd == CMD_READ)
                c.idx = RD_IDX_W'($urandom_range(0, tbl_count - 1));
        end
        return c;
    endfunction

    function automatic void stage(logic [1:0] op, logic [SEV_W-1:0] sv,
                                  logic [ID_W-1:0] id, logic [RD_IDX_W-1:0] ix);
        staged_cmd_t s;
        s.c.cmd = op;
        s.c.sev = sv;
        s.c.ack_id = id;
        s.c.idx = ix;
        s.aim = 1'b0;
        pending_q.push_back(s);
    endfunction

    function automatic void stage_random(int raise_pct, int ack_pct, int n);
        staged_cmd_t s;
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            s.c.sev = SEV_W'($urandom);
            s.c.ack_id = $urandom;
            s.c.idx = RD_IDX_W'($urandom);
            s.aim = ($urandom_range(0, 3) != 0);
            if (r < raise_pct)
                s.c.cmd = CMD_RAISE;
            else if (r < raise_pct + ack_pct)
                s.c.cmd = CMD_ACK;
            else if (r < 95)
                s.c.cmd = CMD_READ;
            else
                s.c.cmd = CMD_UNUSED;
            pending_q.push_back(s);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : sender
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp_q.push_back(apply_command(offered));
                items_sent++;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_q.size() != 0 &&
                    ((items_sent >= 800 && items_sent < 1000) || $urandom_range(0, 99) >= 24))
                begin
                    offered = aim_command(pending_q.pop_front());
                    req_valid <= 1'b1;
                    cmd <= offered.cmd;
                    severity <= offered.sev;
                    ack_id <= offered.ack_id;
                    read_index <= offered.idx;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (expected_rsp_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: st=%0d cnt=%0d", status, active_count);
                end
                else
                begin
                    want_rsp = expected_rsp_q.pop_front();
                    status_hits[want_rsp.status]++;
                    stored_hits += want_rsp.stored;
                    if (status !== want_rsp.status || stored !== want_rsp.stored ||
                        new_id !== want_rsp.new_id || entry_id !== want_rsp.entry_id ||
                        entry_severity !== want_rsp.entry_sev ||
                        active_count !== want_rsp.active_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("result %0d: exp st=%0d sto=%0d nid=%h eid=%h esev=%0d cnt=%0d",
                                results_seen, want_rsp.status, want_rsp.stored,
                                want_rsp.new_id, want_rsp.entry_id, want_rsp.entry_sev,
                                want_rsp.active_count);
                            $display("  got st=%0d sto=%0d nid=%h eid=%h esev=%0d cnt=%0d",
                                status, stored, new_id, entry_id,
                                entry_severity, active_count);
                        end
                    end
                end
                // long hold-off so the input side backs up
                if (results_seen == 300 || results_seen == 1500)
                    hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= !(results_seen >= 800 && results_seen < 1000) &&
                             ($urandom_range(0, 99) < 24);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_alarm_table_compacting: errors");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (pending_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_silenced(logic v);
        @(posedge clk);
        silenced_we <= 1'b1;
        silenced_wdata <= v;
        @(posedge clk);
        silenced_we <= 1'b0;
        quiet_mode = v;
    endtask

    initial
    begin : main
        int k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, unused code, fill to full, ack oldest and newest
        stage(CMD_READ, 3'd0, 32'h0, 8'hFF);
        stage(CMD_READ, 3'd7, 32'hFFFF_FFFF, 8'h00);
        stage(CMD_ACK, 3'd0, 32'hFFFF_FFFF, 8'h00);
        stage(CMD_ACK, 3'd7, 32'h0, 8'hFF);
        stage(CMD_UNUSED, 3'd7, 32'hFFFF_FFFF, 8'hFF);
        for (k = 0; k < TBL_DEPTH; k++)
            stage(CMD_RAISE, k[SEV_W-1:0], (k % 2) ? 32'hFFFF_FFFF : 32'h0,
                  (k % 2) ? 8'h00 : 8'hFF);
        stage(CMD_RAISE, 3'd7, 32'h1, 8'h0);
        stage(CMD_READ, 3'd0, 32'h0, 8'(TBL_DEPTH - 1));
        stage(CMD_ACK, 3'd0, 32'h1, 8'h0);
        stage(CMD_ACK, 3'd0, 32'(TBL_DEPTH), 8'h0);
        stage(CMD_READ, 3'd0, 32'h0, 8'(TBL_DEPTH - 1));
        wait_drained();

        write_silenced(1'b1);
        @(negedge clk);
        stage(CMD_RAISE, 3'd7, 32'h0, 8'h0);
        stage(CMD_RAISE, 3'd0, 32'h0, 8'h0);
        stage(CMD_READ, 3'd0, 32'h0, 8'h0);
        stage(CMD_ACK, 3'd0, 32'h2, 8'h0);
        stage_random(40, 30, 100);
        wait_drained();

        write_silenced(1'b0);
        @(negedge clk);
        stage_random(40, 30, 500);
        wait_drained();
        @(negedge clk);
        stage_random(20, 45, 500);
        wait_drained();

        write_silenced(1'b1);
        @(negedge clk);
        stage_random(40, 30, 200);
        wait_drained();

        write_silenced(1'b0);
        @(negedge clk);
        stage_random(55, 25, 500);
        wait_drained();

        repeat (8) @(posedge clk);
        if (expected_rsp_q.size() != 0)
            fail_count += expected_rsp_q.size();
        $display("covered %0d commands with silencing toggled: %0d stored raises,",
                 items_sent, stored_hits);
        $display("  %0d full refusals, %0d ack misses, %0d out-of-range reads, %0d ok results",
                 status_hits[ST_FULL], status_hits[ST_NOT_FOUND],
                 status_hits[ST_BAD_INDEX], status_hits[ST_OK]);
        if (fail_count == 0)
            $display("tb_alarm_table_compacting: clean");
        else
            $display("tb_alarm_table_compacting: errors");
        $finish;
    end
endmodule
